[rtl/core/rhp_pkg.sv]
// Shared types and constants of the pixel colour-space converter.
`timescale 1ns / 1ps

package rhp_pkg;

    localparam int CH_W    = 8;
    localparam int OUT_W   = 16;
    localparam int HUE_W   = 24;
    localparam int SAT_W   = 12;
    localparam int DIFF_W  = CH_W + 1;
    localparam int DEN_W   = 12;
    localparam int NUM_W   = 21;

    localparam int VAL_DIV   = 2561;
    localparam int VAL_SHIFT = 23;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic             vld;
        logic [HUE_W-1:0] hue_num;
        logic [HUE_W-1:0] hue_den;
        logic [SAT_W-1:0] sat_num;
        logic [SAT_W-1:0] sat_den;
        logic [SAT_W-1:0] val_num;
    } front_t;

endpackage

[rtl/core/rhp_front.sv]
// Front stages: max, min and sector select, hue numerator, divider operands.
`timescale 1ns / 1ps

module rhp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [rhp_pkg::CH_W-1:0] blue,
    input  logic [rhp_pkg::CH_W-1:0] green,
    input  logic [rhp_pkg::CH_W-1:0] red,
    output rhp_pkg::front_t        op
);
    import rhp_pkg::*;

    logic [CH_W-1:0]          mx_next;
    logic [CH_W-1:0]          mn_next;
    logic [1:0]               sec_next;
    logic signed [DIFF_W-1:0] diff_next;

    logic                     s1_vld_reg;
    logic [CH_W-1:0]          s1_mx_reg;
    logic [CH_W-1:0]          s1_d_reg;
    logic [1:0]               s1_sec_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;

    logic [DEN_W-1:0]         den_next;
    logic signed [NUM_W-1:0]  base;
    logic signed [NUM_W-1:0]  adj;
    logic signed [NUM_W-1:0]  num_next;

    logic                     s2_vld_reg;
    logic [CH_W-1:0]          s2_mx_reg;
    logic [CH_W-1:0]          s2_d_reg;
    logic [DEN_W-1:0]         s2_den_reg;
    logic signed [NUM_W-1:0]  s2_num_reg;

    logic signed [NUM_W-1:0]  num_fix;
    front_t                   op_next;
    front_t                   op_reg;

    always_comb
    begin
        mx_next = (blue > green) ? blue : green;
        mx_next = (mx_next > red) ? mx_next : red;
        mn_next = (blue < green) ? blue : green;
        mn_next = (mn_next < red) ? mn_next : red;
        priority if (mx_next == red)
        begin
            sec_next  = SEC_RED;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (mx_next == green)
        begin
            sec_next  = SEC_GREEN;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sec_next  = SEC_BLUE;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_comb
    begin
        den_next = DEN_W'({s1_d_reg, 3'b000}) + DEN_W'({s1_d_reg, 1'b0}) + DEN_W'(1);
        unique case (s1_sec_reg)
            SEC_GREEN: base = $signed(NUM_W'(den_next) * NUM_W'(120));
            SEC_BLUE:  base = $signed(NUM_W'(den_next) * NUM_W'(240));
            default:   base = '0;
        endcase
        adj      = NUM_W'(s1_diff_reg) * $signed(NUM_W'(600));
        num_next = base + adj;
    end

    always_comb
    begin
        num_fix = s2_num_reg;
        if (s2_num_reg < 0)
        begin
            num_fix = s2_num_reg + $signed(NUM_W'(s2_den_reg) * NUM_W'(360));
        end
        op_next.vld     = s2_vld_reg;
        op_next.hue_num = HUE_W'(unsigned'(num_fix)) * HUE_W'(10);
        op_next.hue_den = HUE_W'(s2_den_reg) * HUE_W'(3601);
        op_next.sat_num = SAT_W'(s2_d_reg) * SAT_W'(10);
        op_next.sat_den = SAT_W'(s2_mx_reg) * SAT_W'(10) + SAT_W'(1);
        op_next.val_num = SAT_W'(s2_mx_reg) * SAT_W'(10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            op_reg     <= '0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            op_reg     <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mx_reg      <= mx_next;
            s1_d_reg       <= mx_next - mn_next;
            s1_sec_reg     <= sec_next;
            s1_diff_reg    <= diff_next;
            s2_mx_reg      <= s1_mx_reg;
            s2_d_reg       <= s1_d_reg;
            s2_den_reg     <= den_next;
            s2_num_reg     <= num_next;
        end
    end

    assign op = op_reg;

endmodule

[rtl/core/rhp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for num < den.
`timescale 1ns / 1ps

module rhp_div #(
    parameter int W  = 24,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    output logic [QW-1:0] quo
);

    logic [W-1:0]  rem_reg [QW];
    logic [W-1:0]  den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  den_in;
        logic [QW-1:0] quo_in;
        logic [W:0]    rem2;
        logic          ge;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        always_comb
        begin
            rem2     = {rem_in, 1'b0};
            ge       = rem2 >= {1'b0, den_in};
            rem_next = ge ? W'(rem2 - {1'b0, den_in}) : W'(rem2);
            quo_next = {quo_in[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

[rtl/core/rgb_to_hsv_pixel.sv]
// Top level of the pixel RGB to HSV converter.
`timescale 1ns / 1ps
//
// One pixel in, one hue/saturation/value result out.
// Input channel: s_axis_tvalid/tready/tdata carries blue, green and red bytes;
// a transaction completes when tvalid and tready are both high.
// Output channel: m_axis_tvalid/tready/tdata carries hue, saturation and
// value as unsigned Q0.16 fractions, truncated and clamped at 65535.
// Pipeline: three operand stages, FRAC_BITS divider stages and one output
// register lie between the input transaction and output valid.
// Throughput: one pixel per cycle while no stall holds the pipeline; the divider
// stages each resolve one quotient bit, so the pipeline depth follows FRAC_BITS.
// Reset: all valid bits clear, no result is pending and the input is ready.
// Stall: a valid output register holds while m_axis_tready is low; the pipeline
// keeps advancing into empty slots, and stops only when the result at its end
// cannot move, in which case s_axis_tready drops. Nothing is lost or repeated.
//
module rgb_to_hsv_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // hue[15:0], saturation[31:16], value[47:32]
);
    import rhp_pkg::*;

    localparam int VAL_PW = FRAC_BITS + VAL_SHIFT;
    localparam logic [VAL_PW-1:0] VAL_RECIP =
        VAL_PW'(((64'd1 << (FRAC_BITS + VAL_SHIFT)) + 64'(VAL_DIV - 1)) / 64'(VAL_DIV));

    front_t              op;
    logic                adv;
    logic                out_load;
    logic                last_vld;
    logic [FRAC_BITS-1:0] vld_reg;
    logic [FRAC_BITS-1:0] hue_q;
    logic [FRAC_BITS-1:0] sat_q;
    logic [FRAC_BITS-1:0] val_q;
    logic [FRAC_BITS-1:0] val_scaled;
    logic [FRAC_BITS-1:0] val_pipe_reg [FRAC_BITS];
    logic [OUT_W-1:0]    hue_c;
    logic [OUT_W-1:0]    sat_c;
    logic [OUT_W-1:0]    val_c;
    logic                out_vld_reg;
    logic [3*OUT_W-1:0]  out_data_reg;

    assign last_vld      = vld_reg[FRAC_BITS-1];
    assign out_load      = !out_vld_reg || m_axis_tready;
    assign adv           = out_load || !last_vld;
    assign s_axis_tready = adv;

    rhp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .in_vld (s_axis_tvalid),
        .blue   (s_axis_tdata[7:0]),
        .green  (s_axis_tdata[15:8]),
        .red    (s_axis_tdata[23:16]),
        .op     (op)
    );

    rhp_div #(.W(HUE_W), .QW(FRAC_BITS)) u_div_hue (
        .clk (clk),
        .en  (adv),
        .num (op.hue_num),
        .den (op.hue_den),
        .quo (hue_q)
    );

    rhp_div #(.W(SAT_W), .QW(FRAC_BITS)) u_div_sat (
        .clk (clk),
        .en  (adv),
        .num (op.sat_num),
        .den (op.sat_den),
        .quo (sat_q)
    );

    assign val_scaled = FRAC_BITS'((VAL_PW'(op.val_num) * VAL_RECIP) >> VAL_SHIFT);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_pipe_reg[0] <= val_scaled;
            for (int i = 1; i < FRAC_BITS; i++)
            begin
                val_pipe_reg[i] <= val_pipe_reg[i-1];
            end
        end
    end

    assign val_q = val_pipe_reg[FRAC_BITS-1];

    if (FRAC_BITS > OUT_W)
    begin : g_clamp
        assign hue_c = (|hue_q[FRAC_BITS-1:OUT_W]) ? '1 : hue_q[OUT_W-1:0];
        assign sat_c = (|sat_q[FRAC_BITS-1:OUT_W]) ? '1 : sat_q[OUT_W-1:0];
        assign val_c = (|val_q[FRAC_BITS-1:OUT_W]) ? '1 : val_q[OUT_W-1:0];
    end
    else
    begin : g_extend
        assign hue_c = OUT_W'(hue_q);
        assign sat_c = OUT_W'(sat_q);
        assign val_c = OUT_W'(val_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[FRAC_BITS-2:0], op.vld};
            end
            if (out_load)
            begin
                out_vld_reg <= last_vld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {val_c, sat_c, hue_c};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(last_vld))
        else $error("pipeline tail moved while stalled");

    a_tail_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && last_vld |=> m_axis_tvalid)
        else $error("finished result did not reach the output register");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("output register changed while held");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && last_vld)
        else $error("input stalled without a blocked result");

endmodule
